### sv/life_gen_pkg.sv
// ----------------------------------------------------------------------------
// life_gen_pkg
// Shared types and constants of the life automaton generation block.
// ----------------------------------------------------------------------------
package life_gen_pkg;

   localparam int DEFAULT_GRID_WIDTH  = 64;
   localparam int DEFAULT_GRID_HEIGHT = 64;

   // neighbour counts of the rule
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_STEP  = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_MODIFY,
      ST_SWEEP,
      ST_DONE
   } state_type;

endpackage

### sv/life_gen_row_next.sv
// ----------------------------------------------------------------------------
// life_gen_row_next
// Row-wide rule unit: next generation of one row from three old rows.
// ----------------------------------------------------------------------------
module life_gen_row_next
   import life_gen_pkg::*;
#(
   parameter int GRID_WIDTH = DEFAULT_GRID_WIDTH
) (
   input  logic [GRID_WIDTH-1:0] above,
   input  logic [GRID_WIDTH-1:0] middle,
   input  logic [GRID_WIDTH-1:0] below,
   output logic [GRID_WIDTH-1:0] next_row
);

   // border columns keep their value
   assign next_row[0]            = middle[0];
   assign next_row[GRID_WIDTH-1] = middle[GRID_WIDTH-1];

   for (genvar x = 1; x < GRID_WIDTH - 1; x++) begin : g_col
      logic [3:0] count;

      assign count = 4'(above[x-1]) + 4'(above[x]) + 4'(above[x+1])
                   + 4'(middle[x-1]) + 4'(middle[x+1])
                   + 4'(below[x-1]) + 4'(below[x]) + 4'(below[x+1]);

      assign next_row[x] = (count == BIRTH_COUNT) || (middle[x] && (count == SURVIVE_COUNT));
   end

endmodule

### sv/life_automaton_generation.sv
// ----------------------------------------------------------------------------
// life_automaton_generation
// Conway life grid held in a row-wide memory, with cell access and stepping.
// ----------------------------------------------------------------------------
// Usage:
// - request channel (req_*): func selects write cell, step one generation or
//   read cell; col/row address the cell, cell_in is the value to write.
// - response channel (rsp_*): one transfer per request; rsp_cell_out is the
//   cell value for a read and zero otherwise.
// - the grid is a memory of GRID_HEIGHT rows of GRID_WIDTH bits with one
//   write and one registered read port; a single row-wide rule unit is reused
//   for every row of a step.
// - from request to response: an unused code or a cell outside the grid
//   goes straight to the response state, a read or write fetches the row,
//   then patches or selects the bit, and a step reads one row per cycle and
//   writes each new interior row two rows behind the row being read.
// - one request at a time: req_stall is high until the response is loaded
//   into the output register.
// - after reset the memory is cleared one row per cycle, with req_stall high.
// - a stalled response holds in the output register; the next request is
//   taken meanwhile and waits in its last state until the register frees.
// ----------------------------------------------------------------------------
module life_automaton_generation
   import life_gen_pkg::*;
#(
   parameter int GRID_WIDTH  = DEFAULT_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEFAULT_GRID_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [5:0] req_col,
   input  logic [5:0] req_row,
   input  logic       req_cell_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_cell_out
);

   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int CNT_W = $clog2(GRID_HEIGHT + 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   write_ff, write_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic                   val_ff, val_in;
   logic                   result_ff, result_in;
   logic [GRID_WIDTH-1:0]  above_ff, above_in;
   logic [GRID_WIDTH-1:0]  middle_ff, middle_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_cell_out_ff, rsp_cell_out_in;

   logic [GRID_WIDTH-1:0]  mem [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0]  mem_rd_ff;
   logic                   mem_we;
   logic [ROW_W-1:0]       mem_waddr;
   logic [GRID_WIDTH-1:0]  mem_wdata;
   logic                   mem_re;
   logic [ROW_W-1:0]       mem_raddr;

   logic                   accept;
   logic                   in_grid;
   logic                   rsp_free;
   logic [CNT_W-1:0]       cnt_less2;
   logic [GRID_WIDTH-1:0]  patched_row;
   logic [GRID_WIDTH-1:0]  next_row;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign in_grid   = (32'(req_col) < 32'(GRID_WIDTH)) && (32'(req_row) < 32'(GRID_HEIGHT));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_less2 = cnt_ff - CNT_W'(2);

   always_comb begin
      patched_row         = mem_rd_ff;
      patched_row[col_ff] = val_ff;
   end

   life_gen_row_next #(
      .GRID_WIDTH (GRID_WIDTH)
   ) u_row_next (
      .above    (above_ff),
      .middle   (middle_ff),
      .below    (mem_rd_ff),
      .next_row (next_row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CNT_W'(GRID_HEIGHT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_STEP) begin
                  state_in = ST_SWEEP;
               end else if ((req_func == FUNC_WRITE || req_func == FUNC_READ) && in_grid) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FETCH:  state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_DONE;
         ST_SWEEP: begin
            if (cnt_ff == CNT_W'(GRID_HEIGHT)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = row_ff;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = row_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ROW_W-1:0];
         end
         ST_FETCH: begin
            mem_re = 1'b1;
         end
         ST_MODIFY: begin
            mem_we    = write_ff;
            mem_wdata = patched_row;
         end
         ST_SWEEP: begin
            if (cnt_ff < CNT_W'(GRID_HEIGHT)) begin
               mem_re    = 1'b1;
               mem_raddr = cnt_ff[ROW_W-1:0];
            end
            // interior rows only: the new row is written two rows behind the row being read
            if (cnt_ff >= CNT_W'(3)) begin
               mem_we    = 1'b1;
               mem_waddr = cnt_less2[ROW_W-1:0];
               mem_wdata = next_row;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      cnt_in          = cnt_ff;
      write_in        = write_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      val_in          = val_ff;
      result_in       = result_ff;
      above_in        = above_ff;
      middle_in       = middle_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_cell_out_in = rsp_cell_out_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               write_in  = (req_func == FUNC_WRITE);
               row_in    = ROW_W'(req_row);
               col_in    = COL_W'(req_col);
               val_in    = req_cell_in;
               result_in = 1'b0;
            end
         end
         ST_MODIFY: begin
            result_in = write_ff ? 1'b0 : mem_rd_ff[col_ff];
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               above_in  = middle_ff;
               middle_in = mem_rd_ff;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_cell_out_in = result_ff;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      write_ff        <= write_in;
      row_ff          <= row_in;
      col_ff          <= col_in;
      val_ff          <= val_in;
      result_ff       <= result_in;
      above_ff        <= above_in;
      middle_ff       <= middle_in;
      rsp_cell_out_ff <= rsp_cell_out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rd_ff <= mem[mem_raddr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_out_ff;

endmodule

### bench/life_automaton_generation_tb.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_tb
// Drives cell writes, cell reads and generation steps into the life grid
// block and checks every response against a cell-level model of the grid.
// Small random colonies are seeded at random spots, near the border too,
// stepped a few times and probed around their window. Stray items are mixed
// in. Both handshake sides idle at random in several phases.
// ----------------------------------------------------------------------------
module life_automaton_generation_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import life_gen_pkg::*;

   localparam int GRID_W = DEFAULT_GRID_WIDTH;
   localparam int GRID_H = DEFAULT_GRID_HEIGHT;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = GRID_H + 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [1:0] func;
      logic [5:0] col;
      logic [5:0] row;
      logic       cell_out;
   } cell_expect_type;

   class life_grid_model_type;
      bit cells [GRID_H][GRID_W];
      cell_expect_type cell_out_pending [$];
      int mismatches;

      function void next_generation();
         bit prior [GRID_H][GRID_W];
         int n;
         prior = cells;
         for (int y = 1; y < GRID_H - 1; y++) begin
            for (int x = 1; x < GRID_W - 1; x++) begin
               n = 0;
               for (int dy = -1; dy <= 1; dy++)
                  for (int dx = -1; dx <= 1; dx++)
                     if (dx != 0 || dy != 0) n += prior[y + dy][x + dx];
               if (prior[y][x]) cells[y][x] = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
               else cells[y][x] = (n == BIRTH_COUNT);
            end
         end
      endfunction

      function void take_request(logic [1:0] func, logic [5:0] col, logic [5:0] row,
                                 logic cell_in);
         cell_expect_type expected;
         expected.func = func;
         expected.col = col;
         expected.row = row;
         expected.cell_out = 1'b0;
         case (func)
            FUNC_WRITE: begin
               if (col < GRID_W && row < GRID_H) cells[row][col] = cell_in;
            end
            FUNC_STEP: begin
               next_generation();
            end
            FUNC_READ: begin
               if (col < GRID_W && row < GRID_H) expected.cell_out = cells[row][col];
            end
            default: ;
         endcase
         cell_out_pending.push_back(expected);
      endfunction

      function void match_response(logic cell_out);
         cell_expect_type expected;
         if (cell_out_pending.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected response: cell_out %0b", cell_out);
            mismatches++;
            return;
         end
         expected = cell_out_pending.pop_front();
         if (cell_out !== expected.cell_out) begin
            if (mismatches < MAX_REPORTS)
               $display("mismatch func %0d col %0d row %0d: expected cell_out %0b, got %0b",
                        expected.func, expected.col, expected.row, expected.cell_out,
                        cell_out);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_func = FUNC_WRITE;
   logic [5:0] req_col = '0;
   logic [5:0] req_row = '0;
   logic       req_cell_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_cell_out;

   life_grid_model_type grid_model = new();
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int cycle_count = 0;

   life_automaton_generation DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_col      (req_col),
      .req_row      (req_row),
      .req_cell_in  (req_cell_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_cell_out (rsp_cell_out)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("life_automaton_generation_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) grid_model.match_response(rsp_cell_out);
   end

   task automatic send_item(input logic [1:0] func, input logic [5:0] col,
                            input logic [5:0] row, input logic cell_in);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_col <= col;
      req_row <= row;
      req_cell_in <= cell_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      grid_model.take_request(func, col, row, cell_in);
      if (func != FUNC_UNUSED) items_sent++;
   endtask

   // seed a small window, step it a few times and probe around it
   task automatic run_colony();
      int w, h, x0, y0;
      w = $urandom_range(3, 7);
      h = $urandom_range(3, 7);
      if ($urandom_range(3) == 0) x0 = $urandom_range(1) ? 0 : GRID_W - w;
      else x0 = $urandom_range(GRID_W - w);
      if ($urandom_range(3) == 0) y0 = $urandom_range(1) ? 0 : GRID_H - h;
      else y0 = $urandom_range(GRID_H - h);
      for (int y = y0; y < y0 + h; y++)
         for (int x = x0; x < x0 + w; x++)
            if ($urandom_range(1)) send_item(FUNC_WRITE, 6'(x), 6'(y), $urandom_range(99) < 65);
      repeat ($urandom_range(1, 3)) begin
         // step ignores the cell fields
         send_item(FUNC_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                   1'($urandom_range(1)));
         // probe one cell beyond the window too, wrapping at the edges
         repeat ($urandom_range(3, 10))
            send_item(FUNC_READ, 6'(x0 - 1 + $urandom_range(w + 1)),
                      6'(y0 - 1 + $urandom_range(h + 1)), 1'($urandom_range(1)));
      end
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 4))
         send_item(2'($urandom_range(3)), 6'($urandom_range(63)), 6'($urandom_range(63)),
                   1'($urandom_range(1)));
   endtask

   initial begin
      int goal;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // grid comes out of reset dead
      send_item(FUNC_READ, 20, 20, 1'b1);
      // border cells feed births in the corners of the interior
      send_item(FUNC_WRITE, 0, 0, 1'b1);
      send_item(FUNC_WRITE, 1, 0, 1'b1);
      send_item(FUNC_WRITE, 2, 0, 1'b1);
      send_item(FUNC_WRITE, 63, 63, 1'b1);
      send_item(FUNC_WRITE, 63, 62, 1'b1);
      send_item(FUNC_WRITE, 62, 63, 1'b1);
      // vertical blinker
      send_item(FUNC_WRITE, 10, 9, 1'b1);
      send_item(FUNC_WRITE, 10, 10, 1'b1);
      send_item(FUNC_WRITE, 10, 11, 1'b1);
      send_item(FUNC_UNUSED, 63, 63, 1'b1);
      send_item(FUNC_STEP, 63, 63, 1'b1);
      send_item(FUNC_READ, 1, 1, 1'b0);
      send_item(FUNC_READ, 0, 0, 1'b0);
      send_item(FUNC_READ, 62, 62, 1'b0);
      send_item(FUNC_READ, 63, 63, 1'b0);
      send_item(FUNC_READ, 9, 10, 1'b0);
      send_item(FUNC_READ, 10, 10, 1'b0);
      send_item(FUNC_READ, 11, 10, 1'b0);
      send_item(FUNC_READ, 10, 9, 1'b0);
      send_item(FUNC_WRITE, 63, 63, 1'b0);
      send_item(FUNC_READ, 63, 63, 1'b1);

      goal = items_sent;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 54; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 54; end
            default: begin send_gap_pct = 26; recv_stall_pct = 26; end
         endcase
         goal += 232;
         while (items_sent < goal) begin
            if ($urandom_range(4) == 0) run_noise();
            else run_colony();
         end
      end
      req_valid <= 1'b0;

      while (grid_model.cell_out_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (grid_model.mismatches == 0) begin
         $display("life_automaton_generation_tb: done, clean");
      end else begin
         $display("life_automaton_generation_tb: done, errors");
      end
      $finish;
   end

endmodule
